FILE: rtl/fmh64_pkg.sv
// Shared types, constants and mixing helpers for the fast mix hash block.
package fmh64_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int LEN_W  = 32;

    localparam logic [WORD_W-1:0] MIX_MUL = 64'h2127599bf4325c37;
    localparam logic [WORD_W-1:0] ACC_MUL = 64'h880355f21e6d1965;

    localparam int PRE_SHIFT  = 23;
    localparam int POST_SHIFT = 47;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_ERROR = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             last;
        logic [LEN_W-1:0] len;
        logic [WORD_W-1:0] word;
    } cmd_t;

    function automatic logic [WORD_W-1:0] mix_pre(input logic [WORD_W-1:0] x);
        mix_pre = x ^ (x >> PRE_SHIFT);
    endfunction

    function automatic logic [WORD_W-1:0] mix_post(input logic [WORD_W-1:0] x);
        mix_post = x ^ (x >> POST_SHIFT);
    endfunction

endpackage

FILE: rtl/fmh64_front.sv
// Front end: accepts words, tracks the open message and classifies each word.
module fmh64_front #(
    parameter int LENGTH_BITS = fmh64_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          kind,
    input  logic [fmh64_pkg::WORD_W-1:0]  payload,
    input  logic [fmh64_pkg::LEN_W-1:0]   message_length,
    input  logic                          full,
    output logic                          push,
    output fmh64_pkg::cmd_t               cmd
);

    localparam logic [63:0] LEN_MASK =
        (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

    logic [LENGTH_BITS-1:0] rem_reg;
    logic [LENGTH_BITS-1:0] rem_next;
    logic                   open_reg;
    logic                   open_next;

    logic [63:0]                    len64;
    logic                           rem_lt8;
    logic [fmh64_pkg::WORD_W-1:0]   masked;

    assign push    = in_valid && !full;
    assign len64   = {32'b0, message_length} & LEN_MASK;
    assign rem_lt8 = (rem_reg[LENGTH_BITS-1:3] == '0);

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            masked[b*8 +: 8] = (3'(b) < rem_reg[2:0]) ? payload[b*8 +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        open_next = open_reg;
        cmd.op    = fmh64_pkg::OP_START;
        cmd.last  = 1'b0;
        cmd.len   = len64[fmh64_pkg::LEN_W-1:0];
        cmd.word  = payload;
        if (!kind)
        begin
            cmd.last  = (len64 == 64'd0);
            rem_next  = len64[LENGTH_BITS-1:0];
            open_next = (len64 != 64'd0);
        end
        else if (!open_reg)
        begin
            cmd.op = fmh64_pkg::OP_ERROR;
        end
        else
        begin
            cmd.op = fmh64_pkg::OP_DATA;
            if (rem_lt8)
            begin
                cmd.word  = masked;
                cmd.last  = 1'b1;
                rem_next  = '0;
                open_next = 1'b0;
            end
            else
            begin
                rem_next  = rem_reg - LENGTH_BITS'(8);
                cmd.last  = (rem_reg == LENGTH_BITS'(8));
                open_next = (rem_reg != LENGTH_BITS'(8));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            open_reg <= 1'b0;
        end
        else if (push)
        begin
            rem_reg  <= rem_next;
            open_reg <= open_next;
        end
    end

endmodule

FILE: rtl/fmh64_fifo.sv
// Short command queue between the front end and the hashing back end.
module fmh64_fifo #(
    parameter int DEPTH = fmh64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fmh64_pkg::cmd_t push_cmd,
    input  logic            pop,
    output fmh64_pkg::cmd_t head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmh64_pkg::cmd_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/fmh64_back.sv
// Back end: runs the hash arithmetic on a shared 32x32 multiplier and holds the result.
module fmh64_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmh64_pkg::cmd_t               head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fmh64_pkg::WORD_W-1:0]  hash_wide,
    output logic [fmh64_pkg::HALF_W-1:0]  hash_folded,
    output logic                          sequence_error
);

    localparam int W = fmh64_pkg::WORD_W;
    localparam int H = fmh64_pkg::HALF_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_POST = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        J_START    = 2'd0,
        J_DATA_MIX = 2'd1,
        J_DATA_ACC = 2'd2,
        J_FINAL    = 2'd3
    } job_t;

    state_t state_reg;
    state_t state_next;
    job_t   job_reg;
    job_t   job_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    fmh64_pkg::cmd_t cmd_reg;
    fmh64_pkg::cmd_t cmd_next;
    logic [W-1:0] acc_reg;
    logic [W-1:0] acc_next;
    logic [W-1:0] a_reg;
    logic [W-1:0] a_next;
    logic [W-1:0] b_reg;
    logic [W-1:0] b_next;
    logic [W-1:0] prod_reg;
    logic [W-1:0] prod_next;
    logic [W-1:0] sum_reg;
    logic [W-1:0] sum_next;
    logic [W-1:0] res_reg;
    logic [W-1:0] res_next;
    logic         err_reg;
    logic         err_next;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [W-1:0] hash_wide_reg;
    logic [W-1:0] hash_wide_next;
    logic [H-1:0] hash_folded_reg;
    logic [H-1:0] hash_folded_next;
    logic         seq_err_reg;
    logic         seq_err_next;

    logic [H-1:0] mul_a;
    logic [H-1:0] mul_b;
    logic [W-1:0] mul_p;
    logic [W-1:0] post_h;
    logic         out_free;

    assign out_valid      = out_valid_reg;
    assign hash_wide      = hash_wide_reg;
    assign hash_folded    = hash_folded_reg;
    assign sequence_error = seq_err_reg;
    assign out_free       = !out_valid_reg || !out_stall;

    // The three partial products that make up the low 64 bits of a 64x64 product.
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mul_a = a_reg[H-1:0];
                mul_b = b_reg[H-1:0];
            end
            2'd1:
            begin
                mul_a = a_reg[W-1:H];
                mul_b = b_reg[H-1:0];
            end
            default:
            begin
                mul_a = a_reg[H-1:0];
                mul_b = b_reg[W-1:H];
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign post_h = cmd_reg.word ^ sum_reg;

    always_comb
    begin
        state_next       = state_reg;
        job_next         = job_reg;
        cnt_next         = cnt_reg;
        cmd_next         = cmd_reg;
        acc_next         = acc_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        prod_next        = prod_reg;
        sum_next         = sum_reg;
        res_next         = res_reg;
        err_next         = err_reg;
        pop              = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        hash_wide_next   = hash_wide_reg;
        hash_folded_next = hash_folded_reg;
        seq_err_next     = seq_err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    cnt_next = 2'd0;
                    case (head.op)
                        fmh64_pkg::OP_START:
                        begin
                            a_next     = {{(W - fmh64_pkg::LEN_W){1'b0}}, head.len};
                            b_next     = fmh64_pkg::ACC_MUL;
                            job_next   = J_START;
                            state_next = S_MUL;
                        end
                        fmh64_pkg::OP_DATA:
                        begin
                            a_next     = fmh64_pkg::mix_pre(head.word);
                            b_next     = fmh64_pkg::MIX_MUL;
                            job_next   = J_DATA_MIX;
                            state_next = S_MUL;
                        end
                        fmh64_pkg::OP_ERROR:
                        begin
                            res_next   = '0;
                            err_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next = mul_p;
                cnt_next  = cnt_reg + 2'd1;
                case (cnt_reg)
                    2'd0:
                    begin
                        sum_next = '0;
                    end
                    2'd1:
                    begin
                        sum_next = prod_reg;
                    end
                    2'd2:
                    begin
                        sum_next = sum_reg + {prod_reg[H-1:0], {H{1'b0}}};
                    end
                    default:
                    begin
                        sum_next   = sum_reg + {prod_reg[H-1:0], {H{1'b0}}};
                        state_next = S_POST;
                    end
                endcase
            end
            S_POST:
            begin
                cnt_next = 2'd0;
                case (job_reg)
                    J_START:
                    begin
                        if (cmd_reg.last)
                        begin
                            a_next     = fmh64_pkg::mix_pre(post_h);
                            b_next     = fmh64_pkg::MIX_MUL;
                            job_next   = J_FINAL;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            acc_next   = post_h;
                            state_next = S_IDLE;
                        end
                    end
                    J_DATA_MIX:
                    begin
                        a_next     = acc_reg ^ fmh64_pkg::mix_post(sum_reg);
                        b_next     = fmh64_pkg::ACC_MUL;
                        job_next   = J_DATA_ACC;
                        state_next = S_MUL;
                    end
                    J_DATA_ACC:
                    begin
                        acc_next = sum_reg;
                        if (cmd_reg.last)
                        begin
                            a_next     = fmh64_pkg::mix_pre(sum_reg);
                            b_next     = fmh64_pkg::MIX_MUL;
                            job_next   = J_FINAL;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        res_next   = fmh64_pkg::mix_post(sum_reg);
                        err_next   = 1'b0;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    hash_wide_next   = res_reg;
                    hash_folded_next = res_reg[H-1:0] - res_reg[W-1:H];
                    seq_err_next     = err_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= J_START;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        acc_reg         <= acc_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        prod_reg        <= prod_next;
        sum_reg         <= sum_next;
        res_reg         <= res_next;
        err_reg         <= err_next;
        hash_wide_reg   <= hash_wide_next;
        hash_folded_reg <= hash_folded_next;
        seq_err_reg     <= seq_err_next;
    end

endmodule

FILE: rtl/fast_mix_hash_64.sv
// Top level of the streaming 64-bit fast mix hash with its 32-bit fold.
// Every 64-bit multiply runs as three passes of one 32x32 multiplier.
// A data word runs two multiplies in the back end; a final word adds a third for the mix.
// A zero-length start runs its length multiply and then the final mix before its result is given.
// Words queue in a short buffer, so input stalls only when that buffer is full.
// Reset (rst_n low, asynchronous) closes any open message and empties queue and output.
module fast_mix_hash_64 #(
    parameter int LENGTH_BITS = fmh64_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = fmh64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [fmh64_pkg::WORD_W-1:0]  payload,
    input  logic [fmh64_pkg::LEN_W-1:0]   message_length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fmh64_pkg::WORD_W-1:0]  hash_wide,
    output logic [fmh64_pkg::HALF_W-1:0]  hash_folded,
    output logic                          sequence_error
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    fmh64_pkg::cmd_t push_cmd;
    fmh64_pkg::cmd_t head;

    assign in_stall = full;

    fmh64_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .kind           (kind),
        .payload        (payload),
        .message_length (message_length),
        .full           (full),
        .push           (push),
        .cmd            (push_cmd)
    );

    fmh64_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    fmh64_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_wide      (hash_wide),
        .hash_folded    (hash_folded),
        .sequence_error (sequence_error)
    );

endmodule
